[hdl/kpe_pkg.sv]
package kpe_pkg;

	// Result kinds as they appear on the event_kind port.
	typedef enum logic [2:0] {
		KIND_PRESS   = 3'd0,
		KIND_RELEASE = 3'd1,
		KIND_FRAME   = 3'd2,
		KIND_REPEAT  = 3'd3,
		KIND_STATUS  = 3'd4
	} ev_kind_t;

	// Idle timer actions carried by the status result.
	localparam logic [1:0] IDLE_NONE  = 2'd0;
	localparam logic [1:0] IDLE_STOP  = 2'd1;
	localparam logic [1:0] IDLE_START = 2'd2;

	// Key numbers with special handling.
	localparam logic [3:0] KEY_NONE = 4'd0;
	localparam logic [3:0] KEY2     = 4'd2;
	localparam logic [3:0] KEY4     = 4'd4;
	localparam logic [3:0] KEY8     = 4'd8;
	localparam logic [3:0] KEY12    = 4'd12;

	// Command frame numbers. The frames themselves are sent by the host.
	localparam logic [3:0] FRAME_24_ENTER = 4'd1;
	localparam logic [3:0] FRAME_24_EXIT  = 4'd2;
	localparam logic [3:0] FRAME_84_ENTER = 4'd3;
	localparam logic [3:0] FRAME_84_EXIT  = 4'd4;
	localparam logic [3:0] FRAME_8_UP     = 4'd5;

	// One queued event. For a status event the code carries
	// {1'b0, charging, idle_action}.
	typedef struct packed {
		ev_kind_t   kind;
		logic [3:0] code;
	} ev_rec_t;

	// Key number checked at each scan position.
	function automatic logic [3:0] key_num(input logic [3:0] pos);
		logic [3:0] k;
		unique case (pos)
			4'd0:    k = 4'd1;
			4'd1:    k = 4'd2;
			4'd2:    k = 4'd3;
			4'd3:    k = 4'd4;
			4'd4:    k = 4'd5;
			4'd5:    k = 4'd6;
			4'd6:    k = 4'd7;
			4'd7:    k = 4'd8;
			4'd8:    k = 4'd9;
			4'd9:    k = 4'd11;
			4'd10:   k = 4'd12;
			4'd11:   k = 4'd13;
			4'd12:   k = 4'd14;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

[hdl/keypad_event_encoder_with_combos.sv]
// Keypad event encoder with two-key combos.
//
// Input queue side: one request per scan tick carries key_levels, charger_pin
// and hold_awake; it is taken on a clock edge with push high and full low.
// Result queue side: while empty is low the oldest result is on event_kind,
// event_code, charging, idle_action and last; pop takes it. Each tick gives
// its press, release, command frame and repeat-start events in scan order,
// then one status result with last set.
// A result passes through the event queue and then the output register before
// it is visible on the result side. The scan sequencer spends one step on each
// of the thirteen key positions and one on the status result, plus one step
// for each extra event that a position gives, and waits while the queue is
// full; the next tick is taken in the cycle that the status result enters the
// queue.
// Reset clears the held key, the combo mode and the idle restart flag, and
// empties the queue and the output register.
// When the receiver stalls, the event queue fills, the scan sequencer waits,
// and full stays high until the current tick has been fully queued.
module keypad_event_encoder_with_combos
	import kpe_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [12:0] key_levels,
	input  logic        charger_pin,
	input  logic        hold_awake,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_kind,
	output logic [3:0]  event_code,
	output logic        charging,
	output logic [1:0]  idle_action,
	output logic        last
);

	logic    wr_valid;
	logic    wr_ready;
	ev_rec_t wr_rec;
	logic    rd_valid;
	logic    rd_take;
	ev_rec_t rd_rec;

	// Scan sequencer: classifies each key position into events.
	kpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_push     (push),
		.in_full     (full),
		.key_levels  (key_levels),
		.charger_pin (charger_pin),
		.hold_awake  (hold_awake),
		.q_push      (wr_valid),
		.q_ready     (wr_ready),
		.q_rec       (wr_rec)
	);

	// Event queue between the scan and the output side.
	kpe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_rec   (wr_rec),
		.rd_valid (rd_valid),
		.rd_take  (rd_take),
		.rd_rec   (rd_rec)
	);

	// Output register and result formatting.
	kpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (rd_valid),
		.q_take      (rd_take),
		.q_rec       (rd_rec),
		.empty       (empty),
		.pop         (pop),
		.event_kind  (event_kind),
		.event_code  (event_code),
		.charging    (charging),
		.idle_action (idle_action),
		.last        (last)
	);

endmodule

[hdl/kpe_front.sv]
module kpe_front
	import kpe_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_push,
	output logic          in_full,
	input  logic [12:0]   key_levels,
	input  logic          charger_pin,
	input  logic          hold_awake,
	output logic          q_push,
	input  logic          q_ready,
	output ev_rec_t       q_rec
);

	localparam logic [3:0] POS_KEY2    = 4'd1;
	localparam logic [3:0] POS_KEY4    = 4'd3;
	localparam logic [3:0] POS_KEY8    = 4'd7;
	localparam logic [3:0] POS_STATUS  = 4'd13;
	localparam logic [3:0] EV_LIMIT    = 4'd15;

	typedef enum logic [1:0] {
		COMBO_NONE = 2'd0,
		COMBO_24   = 2'd1,
		COMBO_2    = 2'd2,
		COMBO_84   = 2'd3
	} combo_t;

	logic          busy_q;
	logic [3:0]    step_q;
	logic [1:0]    sub_q;
	logic [3:0]    cnt_q;
	logic [3:0]    held_q;
	combo_t        combo_q;
	logic          idle_restart_q;
	logic [12:0]   lv_q;
	logic          chg_q;
	logic          hold_q;

	logic [15:0]   lv_ext;
	logic          lvl;
	logic [3:0]    key;
	logic          is_status;
	ev_rec_t       ev [0:2];
	logic [1:0]    n_ev;
	logic [3:0]    held_nx;
	combo_t        combo_nx;
	logic          idle_nx;
	logic [1:0]    action;
	logic          want_push;
	logic          advance;
	logic          last_sub;
	logic          finish;
	logic          accept;

	assign lv_ext    = {3'b000, lv_q};
	assign lvl       = lv_ext[step_q];
	assign key       = key_num(step_q);
	assign is_status = (step_q == POS_STATUS);

	// One scan check: the events it gives and the key state it leaves.
	always_comb begin
		ev[0]    = '{kind: KIND_PRESS, code: key};
		ev[1]    = '{kind: KIND_PRESS, code: key};
		ev[2]    = '{kind: KIND_PRESS, code: key};
		n_ev     = 2'd0;
		held_nx  = held_q;
		combo_nx = combo_q;
		idle_nx  = idle_restart_q;
		action   = IDLE_NONE;
		if (is_status) begin
			if (held_q != KEY_NONE || hold_q) begin
				idle_nx = 1'b1;
				action  = IDLE_STOP;
			end else if (idle_restart_q) begin
				idle_nx = 1'b0;
				action  = IDLE_START;
			end
			ev[0] = '{kind: KIND_STATUS, code: {1'b0, ~chg_q, action}};
			n_ev  = 2'd1;
		end else if (step_q == POS_KEY2) begin
			if (lvl) begin
				if (held_q != KEY2 && combo_q == COMBO_NONE) begin
					held_nx = KEY2;
					n_ev    = 2'd1;
				end
			end else begin
				ev[0] = '{kind: KIND_RELEASE, code: KEY2};
				ev[1] = '{kind: KIND_RELEASE, code: KEY2};
				if (held_q == KEY2) begin
					held_nx = KEY_NONE;
					n_ev    = 2'd1;
					if (combo_q == COMBO_2) begin
						combo_nx = COMBO_NONE;
					end
				end
				// Key 2 let go first ends its combo with key 4 still down.
				if (combo_q == COMBO_24) begin
					held_nx  = KEY4;
					combo_nx = COMBO_NONE;
					n_ev     = n_ev + 2'd1;
				end
			end
		end else if (step_q == POS_KEY4) begin
			if (lvl) begin
				if (held_q == KEY2 && combo_q == COMBO_NONE) begin
					ev[0]    = '{kind: KIND_FRAME, code: FRAME_24_ENTER};
					combo_nx = COMBO_24;
					held_nx  = KEY4;
					n_ev     = 2'd1;
				end else if (held_q == KEY8 && combo_q == COMBO_NONE) begin
					ev[0]    = '{kind: KIND_FRAME, code: FRAME_84_ENTER};
					combo_nx = COMBO_84;
					held_nx  = KEY4;
					n_ev     = 2'd1;
				end else if (held_q != KEY4) begin
					held_nx = KEY4;
					n_ev    = 2'd1;
				end
			end else if (held_q == KEY4) begin
				unique case (combo_q)
					COMBO_24: begin
						ev[0]    = '{kind: KIND_FRAME, code: FRAME_24_EXIT};
						held_nx  = lv_q[1] ? KEY2 : KEY_NONE;
						combo_nx = COMBO_NONE;
						n_ev     = 2'd1;
					end
					COMBO_84: begin
						ev[0]    = '{kind: KIND_FRAME, code: FRAME_84_EXIT};
						held_nx  = lv_q[7] ? KEY8 : KEY_NONE;
						combo_nx = COMBO_NONE;
						n_ev     = 2'd1;
					end
					COMBO_NONE: begin
						ev[0]   = '{kind: KIND_RELEASE, code: KEY4};
						held_nx = KEY_NONE;
						n_ev    = 2'd1;
					end
					COMBO_2: begin
						n_ev = 2'd0;
					end
				endcase
			end
		end else if (step_q == POS_KEY8) begin
			if (lvl) begin
				if (held_q != KEY8 && combo_q == COMBO_NONE) begin
					held_nx = KEY8;
					n_ev    = 2'd1;
				end
			end else begin
				ev[0] = '{kind: KIND_RELEASE, code: KEY8};
				ev[1] = '{kind: KIND_FRAME, code: FRAME_8_UP};
				ev[2] = '{kind: KIND_RELEASE, code: KEY8};
				if (held_q == KEY8) begin
					held_nx = KEY_NONE;
					n_ev    = 2'd2;
				end
				// Key 8 let go first ends its combo with key 4 still down.
				if (combo_q == COMBO_84) begin
					held_nx  = KEY4;
					combo_nx = COMBO_NONE;
					n_ev     = n_ev + 2'd1;
				end
			end
		end else begin
			ev[1] = '{kind: KIND_REPEAT, code: KEY12};
			if (lvl) begin
				if (held_q != key) begin
					held_nx = key;
					n_ev    = (key == KEY12) ? 2'd2 : 2'd1;
				end
			end else if (held_q == key) begin
				ev[0]   = '{kind: KIND_RELEASE, code: key};
				held_nx = KEY_NONE;
				n_ev    = 2'd1;
			end
		end
	end

	// Handshake towards the queue; events beyond the limit are dropped.
	assign want_push = busy_q && (n_ev != 2'd0) && (is_status || cnt_q != EV_LIMIT);
	assign advance   = busy_q && (!want_push || q_ready);
	assign last_sub  = (n_ev == 2'd0) || (sub_q == 2'(n_ev - 2'd1));
	assign finish    = advance && last_sub && is_status;
	assign in_full   = busy_q && !finish;
	assign accept    = in_push && !in_full;
	assign q_push    = want_push;
	assign q_rec     = ev[sub_q];

	// Scan sequencer and key state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			step_q         <= '0;
			sub_q          <= '0;
			cnt_q          <= '0;
			held_q         <= KEY_NONE;
			combo_q        <= COMBO_NONE;
			idle_restart_q <= 1'b0;
		end else begin
			// Key state moves on once a position has given all its events.
			if (advance && last_sub) begin
				held_q         <= held_nx;
				combo_q        <= combo_nx;
				idle_restart_q <= idle_nx;
			end
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
				sub_q  <= '0;
				cnt_q  <= '0;
			end else if (advance) begin
				if (last_sub) begin
					sub_q <= '0;
					if (is_status) begin
						busy_q <= 1'b0;
						step_q <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end else begin
					sub_q <= sub_q + 2'd1;
				end
				if (want_push && !is_status) begin
					cnt_q <= cnt_q + 4'd1;
				end
			end
		end
	end

	// Levels of the tick being scanned.
	always_ff @(posedge clk) begin
		if (accept) begin
			lv_q   <= key_levels;
			chg_q  <= charger_pin;
			hold_q <= hold_awake;
		end
	end

	// The key 2 only combo mode is never entered.
	a_no_combo_2: assert property (@(posedge clk) disable iff (!arst_n)
		combo_q != COMBO_2)
		else $error("combo mode 2 entered");

	// A combo always leaves its first key out of the held register.
	a_combo_held: assert property (@(posedge clk) disable iff (!arst_n)
		!(combo_q == COMBO_24 && held_q == KEY2) && !(combo_q == COMBO_84 && held_q == KEY8))
		else $error("combo key held during its combo");

	// Between ticks the sequencer rests at the first position.
	a_idle_rest: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (step_q == 4'd0 && sub_q == 2'd0))
		else $error("sequencer not at rest while idle");

	// A request into the queue during the status step is the tick's final one.
	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_ready && is_status) |=> (step_q == 4'd0 && sub_q == 2'd0))
		else $error("scan continued after the status request");

endmodule

[hdl/kpe_fifo.sv]
module kpe_fifo
	import kpe_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_valid,
	output logic    wr_ready,
	input  ev_rec_t wr_rec,
	output logic    rd_valid,
	input  logic    rd_take,
	output ev_rec_t rd_rec
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ev_rec_t            mem_q [0:DEPTH-1];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_rec   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_take && rd_valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Event storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

[hdl/kpe_back.sv]
module kpe_back
	import kpe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_take,
	input  ev_rec_t    q_rec,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] event_kind,
	output logic [3:0] event_code,
	output logic       charging,
	output logic [1:0] idle_action,
	output logic       last
);

	logic       valid_q;
	logic [2:0] kind_q;
	logic [3:0] code_q;
	logic       chg_q;
	logic [1:0] action_q;
	logic       last_q;
	logic       is_status;

	// The output register refills from the queue in the same cycle that its result is taken, if the queue holds an event.
	assign q_take    = q_valid && (!valid_q || pop);
	assign is_status = (q_rec.kind == KIND_STATUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// Unpack the queued event into the result fields.
	always_ff @(posedge clk) begin
		if (q_take) begin
			kind_q   <= q_rec.kind;
			code_q   <= is_status ? 4'd0 : q_rec.code;
			chg_q    <= is_status && q_rec.code[2];
			action_q <= is_status ? q_rec.code[1:0] : IDLE_NONE;
			last_q   <= is_status;
		end
	end

	assign empty       = !valid_q;
	assign event_kind  = kind_q;
	assign event_code  = code_q;
	assign charging    = chg_q;
	assign idle_action = action_q;
	assign last        = last_q;

endmodule

[sim/keypad_event_encoder_with_combos_test.sv]
module keypad_event_encoder_with_combos_test;
	import kpe_pkg::*;

	// Combo modes held by the predictor.
	localparam logic [1:0] COMBO_NONE = 2'd0;
	localparam logic [1:0] COMBO_24   = 2'd1;
	localparam logic [1:0] COMBO_2X   = 2'd2;
	localparam logic [1:0] COMBO_84   = 2'd3;

	// A stimulus row whose results come from the predictor rather than the table.
	localparam int PREDICTED   = -1;
	localparam int MAX_EVENTS  = 15;
	localparam int CYCLE_LIMIT = 100000;
	localparam int LONG_STALL  = 400;

	typedef struct packed {
		ev_kind_t   kind;
		logic [3:0] code;
		logic       charging;
		logic [1:0] idle;
		logic       last;
	} kp_event_t;

	typedef struct {
		logic [12:0] lv;
		logic        pin;
		logic        hold;
		int          n_ev;
		ev_kind_t    k0;
		logic [3:0]  c0;
		ev_kind_t    k1;
		logic [3:0]  c1;
		logic        chg;
		logic [1:0]  idle;
	} req_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [12:0] key_levels;
	logic        charger_pin;
	logic        hold_awake;
	logic        empty;
	logic        pop;
	logic [2:0]  event_kind;
	logic [3:0]  event_code;
	logic        charging;
	logic [1:0]  idle_action;
	logic        last;

	// Predictor state.
	logic [3:0] held;
	logic [1:0] combo;
	logic       idle_restart;

	kp_event_t tick_results[$];
	kp_event_t awaited_events[$];
	req_row_t  directed_rows[$];

	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_stall_req = 1'b0;
	int stall_left = 0;

	keypad_event_encoder_with_combos i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.key_levels  (key_levels),
		.charger_pin (charger_pin),
		.hold_awake  (hold_awake),
		.empty       (empty),
		.pop         (pop),
		.event_kind  (event_kind),
		.event_code  (event_code),
		.charging    (charging),
		.idle_action (idle_action),
		.last        (last)
	);

	always #1 clk = ~clk;

	// Watchdog on the overall run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Appends one event to the current tick, dropping any beyond the limit.
	function automatic void add_event(ev_kind_t k, logic [3:0] c);
		kp_event_t r;
		if (tick_results.size() >= MAX_EVENTS)
			return;
		r.kind = k;
		r.code = c;
		r.charging = 1'b0;
		r.idle = IDLE_NONE;
		r.last = 1'b0;
		tick_results.push_back(r);
	endfunction

	// A key without combo handling: press on a new high level, release when it drops.
	function automatic void plain_key(logic lvl, logic [3:0] key);
		if (lvl) begin
			if (held != key) begin
				held = key;
				add_event(KIND_PRESS, key);
				if (key == KEY12)
					add_event(KIND_REPEAT, KEY12);
			end
		end else if (held == key) begin
			held = KEY_NONE;
			add_event(KIND_RELEASE, key);
		end
	endfunction

	// Works out every result of one scan tick and advances the predictor state.
	function automatic void scan_tick(logic [12:0] lv, logic pin, logic hold);
		kp_event_t st;
		logic [1:0] act;
		tick_results.delete();
		plain_key(lv[0], 4'd1);

		// Key 2, whose release may end the key 2 plus key 4 combo.
		if (lv[1]) begin
			if (held != KEY2 && combo == COMBO_NONE) begin
				held = KEY2;
				add_event(KIND_PRESS, KEY2);
			end
		end else begin
			if (held == KEY2) begin
				held = KEY_NONE;
				add_event(KIND_RELEASE, KEY2);
				if (combo == COMBO_2X)
					combo = COMBO_NONE;
			end
			if (combo == COMBO_24) begin
				held = KEY4;
				combo = COMBO_NONE;
				add_event(KIND_RELEASE, KEY2);
			end
		end

		plain_key(lv[2], 4'd3);

		// Key 4 enters a combo on top of key 2 or key 8 and leaves it on release.
		if (lv[3]) begin
			if (held == KEY2 && combo == COMBO_NONE) begin
				add_event(KIND_FRAME, FRAME_24_ENTER);
				combo = COMBO_24;
				held = KEY4;
			end else if (held == KEY8 && combo == COMBO_NONE) begin
				add_event(KIND_FRAME, FRAME_84_ENTER);
				combo = COMBO_84;
				held = KEY4;
			end
			if (held != KEY4) begin
				held = KEY4;
				add_event(KIND_PRESS, KEY4);
			end
		end else if (held == KEY4) begin
			if (combo == COMBO_24) begin
				add_event(KIND_FRAME, FRAME_24_EXIT);
				held = lv[1] ? KEY2 : KEY_NONE;
				combo = COMBO_NONE;
			end else if (combo == COMBO_84) begin
				add_event(KIND_FRAME, FRAME_84_EXIT);
				held = lv[7] ? KEY8 : KEY_NONE;
				combo = COMBO_NONE;
			end else if (combo == COMBO_NONE) begin
				held = KEY_NONE;
				add_event(KIND_RELEASE, KEY4);
			end
		end

		plain_key(lv[4], 4'd5);
		plain_key(lv[5], 4'd6);
		plain_key(lv[6], 4'd7);

		// Key 8 sends its own frame on release and may end the key 8 combo.
		if (lv[7]) begin
			if (held != KEY8 && combo == COMBO_NONE) begin
				held = KEY8;
				add_event(KIND_PRESS, KEY8);
			end
		end else begin
			if (held == KEY8) begin
				held = KEY_NONE;
				add_event(KIND_RELEASE, KEY8);
				add_event(KIND_FRAME, FRAME_8_UP);
			end
			if (combo == COMBO_84) begin
				held = KEY4;
				combo = COMBO_NONE;
				add_event(KIND_RELEASE, KEY8);
			end
		end

		plain_key(lv[8], 4'd9);
		plain_key(lv[9], 4'd11);
		plain_key(lv[10], 4'd12);
		plain_key(lv[11], 4'd13);
		plain_key(lv[12], 4'd14);

		// Idle timer decision and the closing status result.
		if (held != KEY_NONE || hold) begin
			idle_restart = 1'b1;
			act = IDLE_STOP;
		end else if (idle_restart) begin
			idle_restart = 1'b0;
			act = IDLE_START;
		end else begin
			act = IDLE_NONE;
		end
		st.kind = KIND_STATUS;
		st.code = 4'd0;
		st.charging = ~pin;
		st.idle = act;
		st.last = 1'b1;
		tick_results.push_back(st);
	endfunction

	function automatic req_row_t mk_row(logic [12:0] lv, logic pin, logic hold, int n_ev,
			ev_kind_t k0, logic [3:0] c0, ev_kind_t k1, logic [3:0] c1,
			logic chg, logic [1:0] idle);
		req_row_t r;
		r.lv = lv;
		r.pin = pin;
		r.hold = hold;
		r.n_ev = n_ev;
		r.k0 = k0;
		r.c0 = c0;
		r.k1 = k1;
		r.c1 = c1;
		r.chg = chg;
		r.idle = idle;
		return r;
	endfunction

	// Offers one request, waits for it to be taken, then files its expected results.
	task automatic send_request(input req_row_t r);
		kp_event_t ev;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		key_levels <= r.lv;
		charger_pin <= r.pin;
		hold_awake <= r.hold;
		do @(posedge clk); while (full);

		scan_tick(r.lv, r.pin, r.hold);
		if (r.n_ev == PREDICTED) begin
			foreach (tick_results[i])
				awaited_events.push_back(tick_results[i]);
		end else begin
			ev.charging = 1'b0;
			ev.idle = IDLE_NONE;
			ev.last = 1'b0;
			if (r.n_ev > 0) begin
				ev.kind = r.k0;
				ev.code = r.c0;
				awaited_events.push_back(ev);
			end
			if (r.n_ev > 1) begin
				ev.kind = r.k1;
				ev.code = r.c1;
				awaited_events.push_back(ev);
			end
			ev.kind = KIND_STATUS;
			ev.code = 4'd0;
			ev.charging = r.chg;
			ev.idle = r.idle;
			ev.last = 1'b1;
			awaited_events.push_back(ev);
		end
	endtask

	// Random requests: mostly single keys and key 2/4/8 combo walks, some noise.
	task automatic run_phase(input int n, input int s_pct, input int r_pct);
		req_row_t r;
		int pick;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		r = mk_row(13'd0, 1'b0, 1'b0, PREDICTED, KIND_PRESS, 4'd0, KIND_PRESS, 4'd0,
			1'b0, IDLE_NONE);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				r.lv = 13'd1 << $urandom_range(0, 12);
			end else if (pick < 70) begin
				r.lv = 13'd0;
				r.lv[1] = 1'($urandom_range(0, 1));
				r.lv[3] = 1'($urandom_range(0, 1));
				r.lv[7] = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 3) == 0)
					r.lv[$urandom_range(0, 12)] = 1'b1;
			end else if (pick < 90) begin
				r.lv = 13'($urandom);
			end else begin
				r.lv = 13'd0;
			end
			r.pin = 1'($urandom_range(0, 1));
			r.hold = ($urandom_range(0, 3) == 0);
			send_request(r);
		end
	endtask

	function automatic void report_field(string name, logic [3:0] want, logic [3:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Result side: takes results at random and checks each against the oldest expectation.
	initial begin
		kp_event_t want;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (awaited_events.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d code %0d",
						$time, event_kind, event_code);
					errors++;
				end else begin
					want = awaited_events.pop_front();
					report_field("event_kind", 4'(want.kind), 4'(event_kind));
					report_field("event_code", want.code, event_code);
					report_field("charging", 4'(want.charging), 4'(charging));
					report_field("idle_action", 4'(want.idle), 4'(idle_action));
					report_field("last", 4'(want.last), 4'(last));
				end
			end
			if (long_stall_req) begin
				stall_left = LONG_STALL;
				long_stall_req = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Request side and run control.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		key_levels = 13'd0;
		charger_pin = 1'b1;
		hold_awake = 1'b0;
		held = KEY_NONE;
		combo = COMBO_NONE;
		idle_restart = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: the first rows carry their results, the rest use the predictor.
		directed_rows.push_back(mk_row(13'h0000, 1'b1, 1'b0, 0, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0000, 1'b0, 1'b1, 0, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b1, IDLE_STOP));
		directed_rows.push_back(mk_row(13'h0000, 1'b1, 1'b0, 0, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_START));
		directed_rows.push_back(mk_row(13'h0001, 1'b1, 1'b0, 1, KIND_PRESS, 4'd1,
			KIND_PRESS, 4'd0, 1'b0, IDLE_STOP));
		directed_rows.push_back(mk_row(13'h0000, 1'b1, 1'b0, 1, KIND_RELEASE, 4'd1,
			KIND_PRESS, 4'd0, 1'b0, IDLE_START));
		directed_rows.push_back(mk_row(13'h0400, 1'b0, 1'b0, 2, KIND_PRESS, KEY12,
			KIND_REPEAT, KEY12, 1'b1, IDLE_STOP));
		// All keys, then combo entry, ignored presses, exits and early releases.
		directed_rows.push_back(mk_row(13'h1FFF, 1'b0, 1'b1, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0000, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0002, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h000A, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h000A, 1'b0, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h008A, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0002, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h000A, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0008, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0000, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0080, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0088, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0080, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0000, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0080, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0088, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0008, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h0000, 1'b1, 1'b0, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));
		directed_rows.push_back(mk_row(13'h1000, 1'b1, 1'b1, PREDICTED, KIND_PRESS, 4'd0,
			KIND_PRESS, 4'd0, 1'b0, IDLE_NONE));

		send_idle_pct = 12;
		recv_idle_pct = 57;
		foreach (directed_rows[i])
			send_request(directed_rows[i]);

		run_phase(130, 12, 57);
		run_phase(130, 57, 12);
		// Hold the result side off for a long stretch while requests keep coming.
		long_stall_req = 1'b1;
		run_phase(140, 0, 0);
		push <= 1'b0;

		while (awaited_events.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[keypad_event_encoder_with_combos.f]
hdl/kpe_pkg.sv
hdl/kpe_front.sv
hdl/kpe_fifo.sv
hdl/kpe_back.sv
hdl/keypad_event_encoder_with_combos.sv
sim/keypad_event_encoder_with_combos_test.sv
